// ----- sv/syn_cookie_pad_hash_assert.svh -----
// Assertion shorthands shared by the cookie pipeline modules.
`ifndef SYN_COOKIE_PAD_HASH_ASSERT_SVH
`define SYN_COOKIE_PAD_HASH_ASSERT_SVH

// Checked on every clock edge once reset is released.
`define SCPH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SCPH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/scph_pkg.sv -----
`timescale 1ns / 1ps
package scph_pkg;

   localparam int WORD_W    = 32;
   localparam int PAD_ROWS  = 6;
   localparam int PAD_COLS  = 256;
   localparam int COL_W     = 8;
   localparam int ROW_W     = 3;
   localparam int BANK_DEPTH = 2 * PAD_COLS;
   localparam int BANK_AW   = $clog2(BANK_DEPTH);
   localparam int MSS_W     = 16;
   localparam int CLS_W     = 3;
   localparam int NUM_BOUNDS = 7;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [MSS_W-1:0] MSS_BOUND [NUM_BOUNDS] = '{
      16'd256, 16'd468, 16'd536, 16'd996, 16'd1452, 16'd1460, 16'd8960
   };

   typedef logic [WORD_W-1:0] word_type;

   // sideband carried alongside the hash words
   typedef struct packed {
      logic             sel;
      logic [CLS_W-1:0] cls;
      word_type         key;
   } ctl_type;

   // number of MSS thresholds reached; thresholds ascend so this is the class
   function automatic logic [CLS_W-1:0] mss_class(input logic [MSS_W-1:0] mss);
      logic [CLS_W-1:0] k;
      k = '0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         if (mss >= MSS_BOUND[i]) begin
            k = k + CLS_W'(1);
         end
      end
      return k;
   endfunction

endpackage

// ----- sv/scph_ram.sv -----
`timescale 1ns / 1ps
module scph_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/scph_mul.sv -----
`timescale 1ns / 1ps
module scph_mul #(
   parameter int CARRY_WORDS = 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          valid_in,
   input  scph_pkg::word_type                            a_in,
   input  scph_pkg::word_type                            b_in,
   input  scph_pkg::word_type                            c_in,
   input  logic [CARRY_WORDS-1:0][scph_pkg::WORD_W-1:0]  carry_in,
   input  scph_pkg::ctl_type                             ctl_in,
   output logic                                          valid_out,
   output scph_pkg::word_type                            prod_out,
   output logic [CARRY_WORDS-1:0][scph_pkg::WORD_W-1:0]  carry_out,
   output scph_pkg::ctl_type                             ctl_out
);
   import scph_pkg::*;

   logic                                 valid_ff;
   word_type                             prod_ff, prod_in;
   logic [CARRY_WORDS-1:0][WORD_W-1:0]   carry_ff;
   ctl_type                              ctl_ff;

   // (a ^ b) * c, low word only
   assign prod_in = WORD_W'((a_in ^ b_in) * c_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         carry_ff <= carry_in;
         ctl_ff   <= ctl_in;
      end
   end

   assign valid_out = valid_ff;
   assign prod_out  = prod_ff;
   assign carry_out = carry_ff;
   assign ctl_out   = ctl_ff;

`include "syn_cookie_pad_hash_assert.svh"

   `SCPH_ASSERT(a_mul_valid_src, $rose(valid_out) |-> ($past(valid_in) && $past(en)), "mul stage valid from nowhere")

endmodule

// ----- sv/syn_cookie_pad_hash.sv -----
`timescale 1ns / 1ps
// SYN cookie generator. Each req word is either a pad write (opcode 0) or a cookie
// request (opcode 1). A pad write stores one word straight away and gives no rsp; a
// write to row 6 or 7 is dropped. A cookie request gives exactly one rsp word via bank
// read, both multiply stages and result register; a new req word may be taken every cycle
// unless rsp stalls fill the pipe. The pads live in six banks of 512 words, one per pad row,
// each addressed by pad select and the relevant address or port byte, so all six words are
// read together; the two 32x32 multiplies each get a stage of their own, which sets the
// pipeline depth. A pad write is seen by any request taken after it. Pads are not cleared
// at reset: every pad word a request touches must be written beforehand.
module syn_cookie_pad_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic                            req_pad_select,
   input  logic [scph_pkg::ROW_W-1:0]      req_pad_row,
   input  logic [scph_pkg::COL_W-1:0]      req_pad_column,
   input  scph_pkg::word_type              req_pad_word,
   input  scph_pkg::word_type              req_src_ip,
   input  logic [15:0]                     req_src_port,
   input  scph_pkg::word_type              req_dst_ip,
   input  logic [15:0]                     req_dst_port,
   input  logic [scph_pkg::MSS_W-1:0]      req_max_seg_size,
   input  scph_pkg::word_type              req_initial_seq,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scph_pkg::word_type              rsp_cookie
);
   import scph_pkg::*;

   // per-stage advance: a stage moves when it is empty or its successor moves
   logic en1, en2, en3, en4;
   logic req_acc;

   // stage 1: bank read data plus sideband
   logic                v1_ff, v1_in;
   ctl_type             ctl1_ff, ctl1_in;
   word_type            bank_q [PAD_ROWS];
   logic [COL_W-1:0]    rd_byte [PAD_ROWS];

   // stages 2 and 3: multiplier stages
   logic                                v2, v3;
   word_type                            h1, h2;
   logic [2:0][WORD_W-1:0]              carry2;
   logic [0:0][WORD_W-1:0]              carry3;
   ctl_type                             ctl2, ctl3;

   // stage 4: result word
   logic                v4_ff;
   word_type            cookie_ff, cookie_in;
   word_type            sum;

   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3 || en4;
   assign en2 = !v2 || en3;
   assign en1 = !v1_ff || en2;

   assign req_ready = en1;
   assign req_acc   = req_valid && req_ready;

   // byte that indexes each pad row
   assign rd_byte[0] = req_src_ip[31:24];
   assign rd_byte[1] = req_src_ip[23:16];
   assign rd_byte[2] = req_src_ip[15:8];
   assign rd_byte[3] = req_src_ip[7:0];
   assign rd_byte[4] = req_src_port[7:0];
   assign rd_byte[5] = req_src_port[15:8];

   // one bank per row, address = {pad select, column}
   for (genvar r = 0; r < PAD_ROWS; r++) begin : g_bank
      logic wr_en;
      assign wr_en = req_acc && (req_opcode == OP_WRITE) && (req_pad_row == ROW_W'(r));
      scph_ram #(
         .WIDTH (WORD_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr ({req_pad_select, req_pad_column}),
         .wr_data (req_pad_word),
         .rd_en   (en1),
         .rd_addr ({req_pad_select, rd_byte[r]}),
         .rd_data (bank_q[r])
      );
   end

   // MSS class and the address/sequence key are ready at entry
   assign v1_in       = req_acc && (req_opcode == OP_COMPUTE);
   assign ctl1_in.sel = req_pad_select;
   assign ctl1_in.cls = mss_class(req_max_seg_size);
   assign ctl1_in.key = (req_dst_ip ^ {req_dst_port, 16'h0000}) + req_initial_seq;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ctl1_ff <= ctl1_in;
      end
   end

   // h1 = (row0 ^ row1) * row2; rows 3..5 ride along
   scph_mul #(
      .CARRY_WORDS (3)
   ) u_mul_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en2),
      .valid_in  (v1_ff),
      .a_in      (bank_q[0]),
      .b_in      (bank_q[1]),
      .c_in      (bank_q[2]),
      .carry_in  ({bank_q[5], bank_q[4], bank_q[3]}),
      .ctl_in    (ctl1_ff),
      .valid_out (v2),
      .prod_out  (h1),
      .carry_out (carry2),
      .ctl_out   (ctl2)
   );

   // h2 = (h1 ^ row3) * row4; row 5 rides along
   scph_mul #(
      .CARRY_WORDS (1)
   ) u_mul_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en3),
      .valid_in  (v2),
      .a_in      (h1),
      .b_in      (carry2[0]),
      .c_in      (carry2[1]),
      .carry_in  (carry2[2]),
      .ctl_in    (ctl2),
      .valid_out (v3),
      .prod_out  (h2),
      .carry_out (carry3),
      .ctl_out   (ctl3)
   );

   // final xor, key add, then pad select and class into the low nibble
   assign sum       = (h2 ^ carry3[0]) + ctl3.key;
   assign cookie_in = {sum[WORD_W-1:4], ctl3.sel, ctl3.cls};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         cookie_ff <= cookie_in;
      end
   end

   assign rsp_valid  = v4_ff;
   assign rsp_cookie = cookie_ff;

`include "syn_cookie_pad_hash_assert.svh"

   `SCPH_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp valid straight after reset")
   `SCPH_ASSERT(a_write_no_result, (req_acc && (req_opcode == OP_WRITE)) |=> !v1_ff, "pad write entered the hash pipe")
   `SCPH_ASSERT(a_full_stall, (rsp_valid && !rsp_ready && v3 && v2 && v1_ff) |-> !req_ready, "full pipe still taking words")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the SYN cookie block. A local copy of both pads is
// kept in step with every accepted write word; each accepted cookie request is
// hashed against that copy and the expected cookie queued. Returned cookies are
// compared in order as they are taken from the rsp side.
module tb_top;
   import scph_pkg::*;

   // one req word, every field of the channel
   typedef struct {
      logic              opcode;
      logic              pad_select;
      logic [ROW_W-1:0]  pad_row;
      logic [COL_W-1:0]  pad_column;
      word_type          pad_word;
      word_type          src_ip;
      logic [15:0]       src_port;
      word_type          dst_ip;
      logic [15:0]       dst_port;
      logic [MSS_W-1:0]  max_seg_size;
      word_type          initial_seq;
   } cookie_req_type;

   // receiver stall patterns
   localparam int RX_ALWAYS  = 0;
   localparam int RX_SPARSE  = 1;
   localparam int RX_BURSTY  = 2;
   localparam int RX_STARVED = 3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_opcode = OP_WRITE;
   logic              req_pad_select = 1'b0;
   logic [ROW_W-1:0]  req_pad_row = '0;
   logic [COL_W-1:0]  req_pad_column = '0;
   word_type          req_pad_word = '0;
   word_type          req_src_ip = '0;
   logic [15:0]       req_src_port = '0;
   word_type          req_dst_ip = '0;
   logic [15:0]       req_dst_port = '0;
   logic [MSS_W-1:0]  req_max_seg_size = '0;
   word_type          req_initial_seq = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   word_type          rsp_cookie;

   // local image of both pads: [pad_select][row][column]
   word_type          pad_mirror [2][PAD_ROWS][PAD_COLS];
   bit                pad_written [2][PAD_ROWS][PAD_COLS];
   int unsigned       row_words [2][PAD_ROWS];

   word_type          cookie_expect_q [$];
   int unsigned       mismatch_count = 0;
   int unsigned       cookies_seen = 0;

   // sender pacing and receiver hold-off
   bit                pace_enable = 1'b1;
   int unsigned       burst_left = 0;
   int unsigned       hold_cycles = 0;

   syn_cookie_pad_hash u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_pad_select   (req_pad_select),
      .req_pad_row      (req_pad_row),
      .req_pad_column   (req_pad_column),
      .req_pad_word     (req_pad_word),
      .req_src_ip       (req_src_ip),
      .req_src_port     (req_src_port),
      .req_dst_ip       (req_dst_ip),
      .req_dst_port     (req_dst_port),
      .req_max_seg_size (req_max_seg_size),
      .req_initial_seq  (req_initial_seq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cookie       (rsp_cookie)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // MSS class: how many of the seven thresholds the peer MSS reaches
   function automatic logic [CLS_W-1:0] mss_band(input logic [MSS_W-1:0] mss);
      if (mss >= 16'd8960) return 3'd7;
      else if (mss >= 16'd1460) return 3'd6;
      else if (mss >= 16'd1452) return 3'd5;
      else if (mss >= 16'd996) return 3'd4;
      else if (mss >= 16'd536) return 3'd3;
      else if (mss >= 16'd468) return 3'd2;
      else if (mss >= 16'd256) return 3'd1;
      else return 3'd0;
   endfunction

   // rows 6 and 7 do not exist; such writes are dropped
   function automatic void store_pad_word(input cookie_req_type r);
      if (r.pad_row < PAD_ROWS) begin
         pad_mirror[r.pad_select][r.pad_row][r.pad_column] = r.pad_word;
         if (!pad_written[r.pad_select][r.pad_row][r.pad_column]) begin
            pad_written[r.pad_select][r.pad_row][r.pad_column] = 1'b1;
            row_words[r.pad_select][r.pad_row]++;
         end
      end
   endfunction

   // hash chain over the six pad rows, all arithmetic mod 2^32
   function automatic word_type predict_cookie(input cookie_req_type r);
      word_type h;
      h = pad_mirror[r.pad_select][0][r.src_ip[31:24]];
      h = h ^ pad_mirror[r.pad_select][1][r.src_ip[23:16]];
      h = h * pad_mirror[r.pad_select][2][r.src_ip[15:8]];
      h = h ^ pad_mirror[r.pad_select][3][r.src_ip[7:0]];
      h = h * pad_mirror[r.pad_select][4][r.src_port[7:0]];
      h = h ^ pad_mirror[r.pad_select][5][r.src_port[15:8]];
      h = h + (r.dst_ip ^ {r.dst_port, 16'h0000});
      h = h + r.initial_seq;
      return {h[31:4], r.pad_select, mss_band(r.max_seg_size)};
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // biased towards the class thresholds and the ends of the range
   function automatic logic [MSS_W-1:0] pick_mss();
      case ($urandom_range(0, 3))
         0: return MSS_W'($urandom);
         1: return MSS_BOUND[$urandom_range(0, NUM_BOUNDS - 1)]
                   + MSS_W'($urandom_range(0, 2)) - MSS_W'(1);
         2: return MSS_W'($urandom_range(0, 1600));
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   // every field random; the caller narrows what matters
   function automatic cookie_req_type random_req(input logic op, input logic sel);
      cookie_req_type r;
      r.opcode       = op;
      r.pad_select   = sel;
      r.pad_row      = ROW_W'($urandom);
      r.pad_column   = COL_W'($urandom);
      r.pad_word     = $urandom;
      r.src_ip       = $urandom;
      r.src_port     = 16'($urandom);
      r.dst_ip       = $urandom;
      r.dst_port     = 16'($urandom);
      r.max_seg_size = pick_mss();
      r.initial_seq  = $urandom;
      return r;
   endfunction

   // some column of the row that already holds a word
   function automatic logic [COL_W-1:0] pick_written_col(input logic sel, input int row);
      logic [COL_W-1:0] c;
      c = COL_W'($urandom);
      for (int k = 0; k < PAD_COLS; k++) begin
         if (pad_written[sel][row][c]) return c;
         c = c + COL_W'(1);
      end
      return c;
   endfunction

   function automatic int first_empty_row(input logic sel);
      for (int row = 0; row < PAD_ROWS; row++) begin
         if (row_words[sel][row] == 0) return row;
      end
      return -1;
   endfunction

   // cookie request touching only written pad words; force_row >= 0 pins
   // that row's index byte to force_col
   function automatic cookie_req_type random_compute(input logic sel, input int force_row,
                                                     input logic [COL_W-1:0] force_col);
      cookie_req_type r;
      logic [COL_W-1:0] c [PAD_ROWS];
      r = random_req(OP_COMPUTE, sel);
      for (int row = 0; row < PAD_ROWS; row++) begin
         c[row] = (row == force_row) ? force_col : pick_written_col(sel, row);
      end
      r.src_ip   = {c[0], c[1], c[2], c[3]};
      r.src_port = {c[5], c[4]};
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Offer one word and hold it until taken, then update the prediction.
   // Called at a rising edge; valid is only dropped for a gap, so a word that
   // follows straight on keeps valid high without a second assignment.
   task automatic send_word(input cookie_req_type r);
      req_valid        <= 1'b1;
      req_opcode       <= r.opcode;
      req_pad_select   <= r.pad_select;
      req_pad_row      <= r.pad_row;
      req_pad_column   <= r.pad_column;
      req_pad_word     <= r.pad_word;
      req_src_ip       <= r.src_ip;
      req_src_port     <= r.src_port;
      req_dst_ip       <= r.dst_ip;
      req_dst_port     <= r.dst_port;
      req_max_seg_size <= r.max_seg_size;
      req_initial_seq  <= r.initial_seq;
      do @(posedge clock); while (req_ready !== 1'b1);

      if (r.opcode == OP_WRITE) store_pad_word(r);
      else cookie_expect_q.push_back(predict_cookie(r));

      // bursts of random length, random gaps between them
      if (pace_enable) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
         end
      end
   endtask

   // drop valid, then let every outstanding cookie come back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (cookie_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("%0t ns: %s: got %08h, want %08h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: changes stall pattern every so often; a requested hold-off
   // overrides it and is counted down here, one cycle per edge.
   // ---------------------------------------------------------------------
   initial begin
      int rx_mode;
      int unsigned rx_phase;
      rx_mode  = RX_ALWAYS;
      rx_phase = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            if (rx_phase == 0) begin
               rx_mode  = $urandom_range(RX_ALWAYS, RX_STARVED);
               rx_phase = $urandom_range(16, 160);
            end
            rx_phase--;
            case (rx_mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_BURSTY: rsp_ready <= ((rx_phase % 8) < 5);
               default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: every cookie taken must match the oldest one predicted
   // ---------------------------------------------------------------------
   initial begin
      word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            cookies_seen++;
            if (cookie_expect_q.size() == 0) begin
               report_mismatch("cookie with no request outstanding", rsp_cookie, '0);
            end else begin
               want = cookie_expect_q.pop_front();
               if (rsp_cookie !== want)
                  report_mismatch($sformatf("cookie %0d wrong", cookies_seen), rsp_cookie, want);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Columns 0 and 255 of every row of pad 1, writes to the missing rows 6
   // and 7 (must not land anywhere), then cookies over the extreme index
   // bytes with at least one MSS per class and the end values of the other fields.
   task automatic test_directed_edges();
      cookie_req_type r;
      word_type ip_list [4];
      logic [15:0] port_list [4];
      logic [MSS_W-1:0] mss_list [10];
      ip_list   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hFF00_FF00};
      port_list = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
      mss_list  = '{16'd0, 16'd255, 16'd256, 16'd468, 16'd536, 16'd996,
                    16'd1452, 16'd1460, 16'd8960, 16'hFFFF};

      for (int row = 0; row < PAD_ROWS; row++) begin
         r = random_req(OP_WRITE, 1'b1);
         r.pad_row    = ROW_W'(row);
         r.pad_column = 8'h00;
         r.pad_word   = (row == 4) ? 32'h0000_0000 : (row[0] ? $urandom : 32'hFFFF_FFFF);
         send_word(r);
         r.pad_column = 8'hFF;
         r.pad_word   = $urandom | 32'h1;
         send_word(r);
      end
      for (int row = PAD_ROWS; row < 8; row++) begin
         r = random_req(OP_WRITE, 1'b1);
         r.pad_row    = ROW_W'(row);
         r.pad_column = 8'h00;
         r.pad_word   = $urandom;
         send_word(r);
      end

      for (int i = 0; i < 10; i++) begin
         r = random_req(OP_COMPUTE, 1'b1);
         r.src_ip       = ip_list[i % 4];
         r.src_port     = port_list[(i / 2) % 4];
         r.dst_ip       = i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         r.dst_port     = i[1] ? 16'hFFFF : 16'h0000;
         r.initial_seq  = i[2] ? 32'hFFFF_FFFF : ((i < 8) ? 32'h0 : $urandom);
         r.max_seg_size = mss_list[i];
         send_word(r);
      end
   endtask

   // Output held off for a long stretch while requests keep coming, so the
   // pipe fills and req_ready has to fall.
   task automatic test_output_backpressure();
      hold_cycles = 300;
      pace_enable = 1'b0;
      for (int i = 0; i < 60; i++) begin
         send_word(random_compute(1'b1, -1, '0));
      end
      pace_enable = 1'b1;
   endtask

   // Mixed pad writes and cookie requests on both pads. Requests only index
   // words already written; a share of them reads the word just written to
   // catch write-to-read hazards. Dropped writes to rows 6 and 7 are
   // sprinkled in but not counted.
   task automatic test_random_traffic(input int unsigned n_words);
      cookie_req_type r;
      int unsigned done_words;
      logic sel;
      int empty_row;
      int force_row;
      bit fresh;
      logic fresh_sel;
      int fresh_row;
      logic [COL_W-1:0] fresh_col;
      done_words = 0;
      fresh      = 1'b0;
      fresh_sel  = 1'b0;
      fresh_row  = 0;
      fresh_col  = '0;
      while (done_words < n_words) begin
         sel = 1'($urandom_range(0, 1));
         if (fresh && $urandom_range(0, 2) == 0) sel = fresh_sel;
         empty_row = first_empty_row(sel);
         if (empty_row >= 0 || $urandom_range(0, 99) < 42) begin
            r = random_req(OP_WRITE, sel);
            if (empty_row >= 0) r.pad_row = ROW_W'(empty_row);
            else if ($urandom_range(0, 15) == 0) r.pad_row = ROW_W'($urandom_range(6, 7));
            else r.pad_row = ROW_W'($urandom_range(0, PAD_ROWS - 1));
            // a narrow column band gives frequent overwrites of live words
            if ($urandom_range(0, 1) == 0) r.pad_column = COL_W'($urandom_range(0, 15));
            if (r.pad_row < PAD_ROWS) begin
               fresh      = 1'b1;
               fresh_sel  = sel;
               fresh_row  = r.pad_row;
               fresh_col  = r.pad_column;
               done_words++;
            end
         end else begin
            force_row = (fresh && sel == fresh_sel && $urandom_range(0, 1) == 1) ? fresh_row : -1;
            r = random_compute(sel, force_row, fresh_col);
            done_words++;
         end
         send_word(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      settle_block();
      test_output_backpressure();
      settle_block();
      test_random_traffic(1820);
      settle_block();
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("syn_cookie_pad_hash: match");
      end else begin
         $display("syn_cookie_pad_hash: mismatch");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("syn_cookie_pad_hash: mismatch");
      $finish;
   end

endmodule
